// ===== rtl/qenc_pkg.sv =====
// qenc_pkg: shared types and constants for the Q-form encoded-word encoder
// no dependencies; imported by qenc_front, qenc_fifo, qenc_back and the top level
package qenc_pkg;

	// number of charset name bytes the registers hold
	localparam int CS_BYTES = 16;
	localparam int LEN_W    = 5;

	// line-length limits for folding
	localparam int FOLD_SOFT = 64;
	localparam int FOLD_HARD = 72;

	// body form of one text byte inside an encoded word
	localparam logic [1:0] KIND_PLAIN = 2'd0;
	localparam logic [1:0] KIND_UNDER = 2'd1;
	localparam logic [1:0] KIND_HEX   = 2'd2;

	// character codes
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_QM    = 8'h3F;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_UQ    = 8'h51;
	localparam logic [7:0] CH_LQ    = 8'h71;

	// work descriptor from the classifier to the byte sequencer
	typedef struct packed {
		logic       pass;    // all-ascii text, byte goes out unchanged
		logic       prefix;  // open a new encoded word first
		logic [1:0] kind;    // body form
		logic       fold;    // close word and fold the line after the body
		logic       close;   // close the word at the end of text
		logic [7:0] ch;      // raw text byte
	} desc_t;

	// configuration seen by the datapath
	typedef struct packed {
		logic [8*CS_BYTES-1:0] charset;
		logic [LEN_W-1:0]      len;     // effective charset length, clamped
		logic                  upper;
	} cfg_t;

endpackage

// ===== rtl/qenc_front.sv =====
// qenc_front: accepts text bytes, tracks the high-byte note and line length,
// and turns each emit-pass byte into a work descriptor; depends on qenc_pkg
module qenc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  qenc_pkg::cfg_t     cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [7:0]         text_byte,
	input  logic               final_byte,
	input  logic               q_full,
	output logic               q_push,
	output qenc_pkg::desc_t    q_desc
);
	import qenc_pkg::*;

	logic       saw_q;
	logic [6:0] lc_q;
	logic       accept;
	logic       special;
	logic       ws;
	logic [6:0] base;
	logic [6:0] lc1;
	logic       fold;
	logic [1:0] kind;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept && op;

	// byte classes
	always_comb begin
		special = text_byte inside {8'h3D, 8'h3F, 8'h5F, 8'h28, 8'h29, 8'h5B, 8'h5D,
			8'h3C, 8'h3E, 8'h2C, 8'h3B, 8'h3A, 8'h2E, 8'h40};
		ws = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
			(text_byte == CH_CR) || (text_byte == CH_LF);
		if (text_byte == CH_SPACE) begin
			kind = KIND_UNDER;
		end else if (special || text_byte <= CH_SPACE || text_byte >= 8'd127) begin
			kind = KIND_HEX;
		end else begin
			kind = KIND_PLAIN;
		end
	end

	// line length after this byte and the fold decision
	always_comb begin
		base = (lc_q == 7'd0) ? (7'(cfg.len) + 7'd5) : lc_q;
		lc1  = base + ((kind == KIND_HEX) ? 7'd3 : 7'd1);
		fold = (lc1 >= 7'(FOLD_SOFT) && ws) || (lc1 >= 7'(FOLD_HARD));
	end

	// descriptor for the sequencer
	always_comb begin
		q_desc.pass   = !saw_q;
		q_desc.prefix = (lc_q == 7'd0);
		q_desc.kind   = kind;
		q_desc.fold   = fold;
		q_desc.close  = final_byte && !fold;
		q_desc.ch     = text_byte;
	end

	// high-byte note and line length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saw_q <= 1'b0;
			lc_q  <= 7'd0;
		end else if (accept) begin
			if (!op) begin
				if (text_byte > 8'd127) saw_q <= 1'b1;
			end else if (final_byte) begin
				saw_q <= 1'b0;
				lc_q  <= 7'd0;
			end else if (saw_q) begin
				lc_q <= fold ? 7'd0 : lc1;
			end
		end
	end

endmodule

// ===== rtl/qenc_fifo.sv =====
// qenc_fifo: short descriptor queue between the classifier and the sequencer
// depends on qenc_pkg for the descriptor type
module qenc_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  qenc_pkg::desc_t wr_desc,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output qenc_pkg::desc_t head
);
	import qenc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	desc_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_desc;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

// ===== rtl/qenc_back.sv =====
// qenc_back: byte sequencer that expands each descriptor into output bytes
// (pass, prefix, body, fold, close) into an output register; depends on qenc_pkg
module qenc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  qenc_pkg::cfg_t  cfg,
	input  logic            head_valid,
	input  qenc_pkg::desc_t head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            run_end
);
	import qenc_pkg::*;

	localparam logic [2:0] PH_PASS   = 3'd0;
	localparam logic [2:0] PH_PREFIX = 3'd1;
	localparam logic [2:0] PH_BODY   = 3'd2;
	localparam logic [2:0] PH_FOLD   = 3'd3;
	localparam logic [2:0] PH_CLOSE  = 3'd4;
	localparam logic [2:0] PH_DONE   = 3'd5;

	logic       active_q;
	logic [2:0] phase_q;
	logic [4:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_end_q;

	logic [2:0] cur_phase;
	logic [4:0] cur_idx;
	logic [2:0] next_phase;
	logic [3:0] cs_idx;
	logic [7:0] byte_d;
	logic       seg_last;
	logic       job_last;
	logic       load;
	logic       emit;

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		return (v < 4'd10) ? (8'h30 + 8'(v)) : (8'h37 + 8'(v));
	endfunction

	assign load = !out_valid_q || out_ready;
	assign emit = head_valid && load;
	assign pop  = emit && job_last;

	// current step of the head descriptor
	always_comb begin
		if (active_q) begin
			cur_phase = phase_q;
			cur_idx   = idx_q;
		end else begin
			cur_phase = head.pass ? PH_PASS : (head.prefix ? PH_PREFIX : PH_BODY);
			cur_idx   = '0;
		end
		cs_idx = 4'(cur_idx - 5'd2);
	end

	// byte for this step and end of segment
	always_comb begin
		byte_d   = head.ch;
		seg_last = 1'b0;
		case (cur_phase)
			PH_PASS: begin
				byte_d   = head.ch;
				seg_last = 1'b1;
			end
			PH_PREFIX: begin
				seg_last = (cur_idx == cfg.len + 5'd4);
				if (cur_idx == 5'd0) begin
					byte_d = CH_EQ;
				end else if (cur_idx == 5'd1) begin
					byte_d = CH_QM;
				end else if (cur_idx < cfg.len + 5'd2) begin
					byte_d = cfg.charset[{cs_idx, 3'b000} +: 8];
				end else if (cur_idx == cfg.len + 5'd3) begin
					byte_d = cfg.upper ? CH_UQ : CH_LQ;
				end else begin
					byte_d = CH_QM;
				end
			end
			PH_BODY: begin
				case (head.kind)
					KIND_UNDER: begin
						byte_d   = CH_UNDER;
						seg_last = 1'b1;
					end
					KIND_HEX: begin
						seg_last = (cur_idx == 5'd2);
						if (cur_idx == 5'd0) byte_d = CH_EQ;
						else if (cur_idx == 5'd1) byte_d = hex_digit(head.ch[7:4]);
						else byte_d = hex_digit(head.ch[3:0]);
					end
					default: begin
						byte_d   = head.ch;
						seg_last = 1'b1;
					end
				endcase
			end
			PH_FOLD: begin
				seg_last = (cur_idx == 5'd4);
				case (cur_idx)
					5'd0:    byte_d = CH_QM;
					5'd1:    byte_d = CH_EQ;
					5'd2:    byte_d = CH_CR;
					5'd3:    byte_d = CH_LF;
					default: byte_d = CH_SPACE;
				endcase
			end
			PH_CLOSE: begin
				seg_last = (cur_idx == 5'd1);
				byte_d   = (cur_idx == 5'd0) ? CH_QM : CH_EQ;
			end
			default: begin
				byte_d   = head.ch;
				seg_last = 1'b1;
			end
		endcase
	end

	// segment that follows the current one
	always_comb begin
		case (cur_phase)
			PH_PREFIX: next_phase = PH_BODY;
			PH_BODY:   next_phase = head.fold ? PH_FOLD : (head.close ? PH_CLOSE : PH_DONE);
			default:   next_phase = PH_DONE;
		endcase
		job_last = seg_last && (next_phase == PH_DONE);
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			phase_q  <= PH_PASS;
			idx_q    <= '0;
		end else if (emit) begin
			if (job_last) begin
				active_q <= 1'b0;
			end else if (seg_last) begin
				active_q <= 1'b1;
				phase_q  <= next_phase;
				idx_q    <= '0;
			end else begin
				active_q <= 1'b1;
				phase_q  <= cur_phase;
				idx_q    <= cur_idx + 5'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= byte_d;
			run_end_q  <= job_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_end   = run_end_q;

	// checks
	a_active_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> head_valid)
		else $error("sequencer active without a queued descriptor");
	a_pop_marks_end: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q && run_end_q)
		else $error("finished descriptor without end mark");
	a_pass_single: assert property (@(posedge clk) disable iff (!arst_n)
		emit && cur_phase == PH_PASS |-> job_last)
		else $error("pass-through byte not a single transfer");
	a_fold_no_close: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> !(head.fold && head.close))
		else $error("fold and close on the same byte");

endmodule

// ===== rtl/mime_q_encoded_word_encoder.sv =====
// Q-form encoded-word encoder, top level: register port, classifier, queue, sequencer.
// Each emit-pass byte goes through the descriptor queue and then the sequencer, which
// registers every output byte in its output register before out_valid shows it.
// The sequencer gives one output byte per cycle while a descriptor waits and out_ready
// holds; an emit-pass byte yields 1 or 3 body bytes, plus charset length + 5 bytes
// when a word opens, 5 on a fold and 2 on close. Scan-pass bytes are taken by the
// classifier and give no output; input stalls while the descriptor queue is full.
// Reset clears the high-byte note, line length, queue and registers to reset values.
module mime_q_encoded_word_encoder #(
	parameter int MAX_CHARSET_LEN = 16,
	parameter int QUEUE_DEPTH     = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [7:0]  text_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        run_end
);
	import qenc_pkg::*;

	localparam logic [1:0] REG_CS_LOW  = 2'd0;
	localparam logic [1:0] REG_CS_HIGH = 2'd1;
	localparam logic [1:0] REG_CS_LEN  = 2'd2;
	localparam logic [1:0] REG_UPPER   = 2'd3;
	localparam int LenCap = (MAX_CHARSET_LEN < CS_BYTES) ? MAX_CHARSET_LEN : CS_BYTES;

	logic [63:0]      cs_low_q;
	logic [63:0]      cs_high_q;
	logic [LEN_W-1:0] cs_len_q;
	logic             upper_q;
	logic             wr_en;
	logic [1:0]       reg_idx;
	cfg_t             cfg;

	logic  q_push;
	logic  q_pop;
	logic  q_full;
	logic  q_head_valid;
	desc_t q_wr;
	desc_t q_head;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];
	assign wr_en   = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_low_q  <= '0;
			cs_high_q <= '0;
			cs_len_q  <= '0;
			upper_q   <= 1'b1;
		end else if (wr_en) begin
			case (reg_idx)
				REG_CS_LOW:  cs_low_q  <= pwdata;
				REG_CS_HIGH: cs_high_q <= pwdata;
				REG_CS_LEN:  cs_len_q  <= pwdata[LEN_W-1:0];
				REG_UPPER:   upper_q   <= pwdata[0];
				default:     upper_q   <= upper_q;
			endcase
		end
	end

	// register read
	always_comb begin
		case (reg_idx)
			REG_CS_LOW:  prdata = cs_low_q;
			REG_CS_HIGH: prdata = cs_high_q;
			REG_CS_LEN:  prdata = 64'(cs_len_q);
			REG_UPPER:   prdata = 64'(upper_q);
			default:     prdata = '0;
		endcase
	end

	// datapath view of the configuration, charset length clamped
	always_comb begin
		cfg.charset = {cs_high_q, cs_low_q};
		cfg.len     = (cs_len_q > LEN_W'(LenCap)) ? LEN_W'(LenCap) : cs_len_q;
		cfg.upper   = upper_q;
	end

	qenc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_desc     (q_wr)
	);

	qenc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.wr_desc    (q_wr),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	qenc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_end    (run_end)
	);

endmodule
